/* src/keypad_code_entry_macros.svh */
// Assertion helpers for the keypad code entry block.
`ifndef KEYPAD_CODE_ENTRY_MACROS_SVH
`define KEYPAD_CODE_ENTRY_MACROS_SVH

// Check a condition in the same cycle as its trigger.
`define KCE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("keypad_code_entry: check failed");

// Check a condition in the cycle after its trigger.
`define KCE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("keypad_code_entry: check failed");

`endif

/* src/kce_pkg.sv */
package kce_pkg;

  localparam int MAX_DIGITS = 4;
  localparam int CntW = $clog2(MAX_DIGITS + 1);
  localparam int IdxW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int TextChars = (MAX_DIGITS < 4) ? MAX_DIGITS : 4;

  localparam int KeyArrived = 3;
  localparam int KeyLeft = 7;
  localparam int KeyDelD = 11;
  localparam int KeyDelStar = 12;
  localparam int KeyDelX = 15;

  localparam logic [9:0] PULSE_KEY = 10'd30;
  localparam logic [9:0] PULSE_SUBMIT = 10'd100;
  localparam logic [9:0] PULSE_DELETE = 10'd500;
  localparam logic [9:0] PULSE_OVERFLOW = 10'd1000;

  typedef enum logic [2:0] {
    ACT_ADDED    = 3'd0,
    ACT_MULTI    = 3'd1,
    ACT_ARRIVED  = 3'd2,
    ACT_LEFT     = 3'd3,
    ACT_DELETE   = 3'd4,
    ACT_OVERFLOW = 3'd5
  } action_t;

  typedef enum logic [2:0] {
    CMD_ARRIVED,
    CMD_LEFT,
    CMD_DELETE,
    CMD_MULTI,
    CMD_KEY
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  ch;
  } cmd_t;

  function automatic logic [7:0] key_char(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:  c = "1";
      4'd1:  c = "2";
      4'd2:  c = "3";
      4'd3:  c = "A";
      4'd4:  c = "4";
      4'd5:  c = "5";
      4'd6:  c = "6";
      4'd7:  c = "L";
      4'd8:  c = "7";
      4'd9:  c = "8";
      4'd10: c = "9";
      4'd11: c = "D";
      4'd12: c = "*";
      4'd13: c = "0";
      4'd14: c = "#";
      default: c = "X";
    endcase
    return c;
  endfunction

endpackage

/* src/keypad_code_entry.sv */
// Keypad code entry: each item on key_state is one 4x4 keypad snapshot
// (bit i = key i, row-major 1 2 3 A / 4 5 6 L / 7 8 9 D / * 0 # X). An
// all-zero snapshot is consumed with no result; every other snapshot gives
// exactly one result: submit on A or L (code_text/code_length carry the
// buffered code, then the buffer clears), clear on D, X or *, overflow clear
// when the buffer is already full, ignore on several keys, otherwise append
// the key's character. Sustained rate is one item per clock while out_ready
// stays high: the classifier feeds a two-entry queue and the back end updates
// the buffer and loads the output register in the same cycle. An accepted
// item is written into the queue and then, when the back end takes it, into
// the output register behind out_valid; in_ready drops only when the queue
// fills behind a stalled output.
`include "keypad_code_entry_macros.svh"

module keypad_code_entry (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] key_state,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  action,
  output logic [9:0]  led_pulse_ms,
  output logic [31:0] code_text,
  output logic [2:0]  code_length
);
  import kce_pkg::*;

  cmd_t    front_cmd;
  logic    front_has_cmd;
  logic    q_full;
  logic    q_push;
  logic    q_pop;
  logic    q_pop_ready;
  logic    head_valid;
  cmd_t    head_cmd;
  action_t back_action;

  kce_front u_front (
    .key_state (key_state),
    .has_cmd   (front_has_cmd),
    .cmd       (front_cmd)
  );

  assign in_ready = !q_full;
  assign q_push = in_valid && in_ready && front_has_cmd;

  kce_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (front_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  kce_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (head_valid),
    .cmd          (head_cmd),
    .cmd_ready    (q_pop_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .action       (back_action),
    .led_pulse_ms (led_pulse_ms),
    .code_text    (code_text),
    .code_length  (code_length)
  );

  assign q_pop = head_valid && q_pop_ready;
  assign action = back_action;

  `KCE_ASSERT_NOW(a_no_text_unless_submit,
    out_valid && action != ACT_ARRIVED && action != ACT_LEFT,
    code_text == 32'd0 && code_length == 3'd0)
  `KCE_ASSERT_NOW(a_length_bound, out_valid, code_length <= 3'(TextChars))
  `KCE_ASSERT_NOW(a_key_pulse,
    out_valid && (action == ACT_ADDED || action == ACT_MULTI),
    led_pulse_ms == PULSE_KEY)
  `KCE_ASSERT_NEXT(a_zero_item_dropped,
    in_valid && in_ready && key_state == 16'd0 && !head_valid,
    !head_valid)

endmodule

/* src/kce_front.sv */
module kce_front (
  input  logic [15:0]   key_state,
  output logic          has_cmd,
  output kce_pkg::cmd_t cmd
);
  import kce_pkg::*;

  logic [3:0] idx;
  logic       multi;

  always_comb begin
    idx = '0;
    for (int j = 0; j < 16; j++) begin
      if (key_state[j]) begin
        idx = idx | 4'(j);
      end
    end
  end

  assign multi = (key_state & (key_state - 16'd1)) != 16'd0;
  assign has_cmd = key_state != 16'd0;

  always_comb begin
    cmd.ch = key_char(idx);
    priority if (key_state[KeyArrived]) begin
      cmd.kind = CMD_ARRIVED;
    end else if (key_state[KeyLeft]) begin
      cmd.kind = CMD_LEFT;
    end else if (key_state[KeyDelD] || key_state[KeyDelX] || key_state[KeyDelStar]) begin
      cmd.kind = CMD_DELETE;
    end else if (multi) begin
      cmd.kind = CMD_MULTI;
    end else begin
      cmd.kind = CMD_KEY;
    end
  end

endmodule

/* src/kce_queue.sv */
module kce_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  kce_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output kce_pkg::cmd_t head_cmd
);
  import kce_pkg::*;

  cmd_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full = fill == 2'd2;
  assign head_valid = fill != 2'd0;
  assign head_cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

/* src/kce_back.sv */
module kce_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  input  kce_pkg::cmd_t    cmd,
  output logic             cmd_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output kce_pkg::action_t action,
  output logic [9:0]       led_pulse_ms,
  output logic [31:0]      code_text,
  output logic [2:0]       code_length
);
  import kce_pkg::*;

  logic [7:0]      chars [MAX_DIGITS];
  logic [7:0]      chars_next [MAX_DIGITS];
  logic [CntW-1:0] count;
  logic [CntW-1:0] count_next;
  logic [CntW-1:0] sub_len;
  logic [31:0]     sub_text;
  action_t         action_next;
  logic [9:0]      pulse_next;
  logic [31:0]     text_next;
  logic [2:0]      length_next;
  logic            step;

  assign cmd_ready = !out_valid || out_ready;
  assign step = cmd_valid && cmd_ready;

  always_comb begin
    sub_len = (count > CntW'(TextChars)) ? CntW'(TextChars) : count;
    sub_text = '0;
    for (int i = 0; i < TextChars; i++) begin
      if (CntW'(i) < count) begin
        sub_text[31 - 8 * i -: 8] = chars[i];
      end
    end
  end

  always_comb begin
    chars_next = chars;
    count_next = count;
    text_next = '0;
    length_next = '0;
    priority if (cmd.kind == CMD_ARRIVED || cmd.kind == CMD_LEFT) begin
      action_next = (cmd.kind == CMD_ARRIVED) ? ACT_ARRIVED : ACT_LEFT;
      pulse_next = PULSE_SUBMIT;
      text_next = sub_text;
      length_next = 3'(sub_len);
      count_next = '0;
      for (int i = 0; i < MAX_DIGITS; i++) chars_next[i] = '0;
    end else if (cmd.kind == CMD_DELETE) begin
      action_next = ACT_DELETE;
      pulse_next = PULSE_DELETE;
      count_next = '0;
      for (int i = 0; i < MAX_DIGITS; i++) chars_next[i] = '0;
    end else if (count >= CntW'(MAX_DIGITS)) begin
      action_next = ACT_OVERFLOW;
      pulse_next = PULSE_OVERFLOW;
      count_next = '0;
      for (int i = 0; i < MAX_DIGITS; i++) chars_next[i] = '0;
    end else if (cmd.kind == CMD_MULTI) begin
      action_next = ACT_MULTI;
      pulse_next = PULSE_KEY;
    end else begin
      action_next = ACT_ADDED;
      pulse_next = PULSE_KEY;
      chars_next[count[IdxW-1:0]] = cmd.ch;
      count_next = count + CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < MAX_DIGITS; i++) chars[i] <= '0;
    end else begin
      if (step) begin
        count <= count_next;
        chars <= chars_next;
      end
      if (cmd_ready) begin
        out_valid <= cmd_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      action <= action_next;
      led_pulse_ms <= pulse_next;
      code_text <= text_next;
      code_length <= length_next;
    end
  end

endmodule
